### hdl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: complex arithmetic unit shared types
// Word formats, queue item, divider stage record and saturation helper.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS     = 16;
  localparam int PROD_BITS     = 2 * WORD_BITS;
  localparam int SUM_BITS      = PROD_BITS + 2;
  localparam int MAG_BITS      = PROD_BITS + 1;
  localparam int REM_BITS      = MAG_BITS + WORD_BITS;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef struct packed {
    action_t action;
    logic    dz;
    word_t   a_re;
    word_t   a_im;
    word_t   b_re;
    word_t   b_im;
  } item_t;

  typedef struct packed {
    logic  ovf;
    word_t val;
  } sat_t;

  typedef struct packed {
    logic                 vld;
    logic                 is_div;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
    logic                 big_re;
    logic                 big_im;
    logic [REM_BITS-1:0]  rem_re;
    logic [REM_BITS-1:0]  rem_im;
    logic [MAG_BITS-1:0]  den;
    logic [WORD_BITS-1:0] q_re;
    logic [WORD_BITS-1:0] q_im;
    sat_t                 pass_re;
    sat_t                 pass_im;
  } div_stage_t;

  function automatic sat_t sat_mag(input logic neg, input logic [MAG_BITS-1:0] mag);
    sat_t                r;
    logic [MAG_BITS-1:0] lim_pos;
    logic [MAG_BITS-1:0] lim_neg;
    lim_pos = MAG_BITS'($unsigned(WORD_MAX));
    lim_neg = lim_pos + MAG_BITS'(1);
    r.ovf   = 1'b0;
    if (neg) begin
      if (mag > lim_neg) begin
        r.ovf = 1'b1;
        r.val = WORD_MIN;
      end else begin
        r.val = word_t'(-mag[WORD_BITS-1:0]);
      end
    end else begin
      if (mag > lim_pos) begin
        r.ovf = 1'b1;
        r.val = WORD_MAX;
      end else begin
        r.val = word_t'(mag[WORD_BITS-1:0]);
      end
    end
    return r;
  endfunction

endpackage

### hdl/complex_arith_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_core: complex add, subtract, multiply and divide
// Signed Q16.16 operands, saturated results with overflow and divide-by-zero.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   action, a_re, a_im, b_re, b_im
//   out      out_valid/out_stall res_re, res_im, div_zero, overflowed
//
// one request per cycle unless held, from intake through the divider pipeline
// pipeline: three arithmetic stages, 32 divider stages, output register
// the whole execution pipeline holds while out_stall holds a valid result
// the four entry queue keeps taking requests during such a hold
// synchronous reset clears queue count and pipeline valid bits
// ----------------------------------------------------------------------------
module complex_arith_unit_core import cau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  word_t      a_re,
  input  word_t      a_im,
  input  word_t      b_re,
  input  word_t      b_im,
  output logic       out_valid,
  input  logic       out_stall,
  output word_t      res_re,
  output word_t      res_im,
  output logic       div_zero,
  output logic       overflowed
);

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_vld;
  item_t wr_item;
  item_t rd_item;

  cau_front u_front (
    .in_valid (in_valid),
    .action   (action),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .item     (wr_item)
  );

  cau_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .full    (q_full),
    .rd_vld  (q_vld),
    .rd_item (rd_item)
  );

  cau_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_vld   (q_vld),
    .item       (rd_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res_re     (res_re),
    .res_im     (res_im),
    .div_zero   (div_zero),
    .overflowed (overflowed)
  );

  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> res_re == '0 && res_im == '0 && !overflowed)
    else $error("divide by zero result not clean");

  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflowed |->
      res_re == WORD_MAX || res_re == WORD_MIN || res_im == WORD_MAX || res_im == WORD_MIN)
    else $error("overflow without saturated part");

  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> $past(out_valid && out_stall))
    else $error("queue full without output hold");

endmodule

### hdl/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front: request intake
// Decodes the action, flags division by a zero operand and pushes the request.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
  input  logic       in_valid,
  input  logic [1:0] action,
  input  word_t      a_re,
  input  word_t      a_im,
  input  word_t      b_re,
  input  word_t      b_im,
  input  logic       q_full,
  output logic       in_stall,
  output logic       push,
  output item_t      item
);

  logic b_zero;

  assign b_zero   = (b_re == '0) && (b_im == '0);
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    item.action = action_t'(action);
    item.dz     = (action_t'(action) == ACT_DIV) && b_zero;
    item.a_re   = a_re;
    item.a_im   = a_im;
    item.b_re   = b_re;
    item.b_im   = b_im;
  end

endmodule

### hdl/cau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_queue: request queue
// Short shift queue between intake and execution, head always in slot zero.
// ----------------------------------------------------------------------------
module cau_queue import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output logic  full,
  output logic  rd_vld,
  output item_t rd_item
);

  item_t                  slot [FIFO_DEPTH];
  logic [FIFO_PTR_BITS:0] cnt;
  logic [FIFO_PTR_BITS:0] cnt_next;
  logic [FIFO_PTR_BITS:0] wr_pos;

  assign full    = (cnt == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
  assign rd_vld  = (cnt != '0);
  assign rd_item = slot[0];
  assign wr_pos  = pop ? cnt - 1'b1 : cnt;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 1'b1;
    end else if (pop && !push) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
    if (push) begin
      slot[wr_pos[FIFO_PTR_BITS-1:0]] <= wr_item;
    end
  end

endmodule

### hdl/cau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div: pipelined restoring divider
// One quotient bit per stage for both result parts, other requests ride along.
// ----------------------------------------------------------------------------
module cau_div import cau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  div_stage_t d_in,
  output div_stage_t d_out
);

  div_stage_t stg [WORD_BITS+1];

  assign stg[0] = d_in;
  assign d_out  = stg[WORD_BITS];

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_stage
    localparam int BIT = WORD_BITS - 1 - k;
    logic [REM_BITS-1:0] dsh;
    logic                ge_re;
    logic                ge_im;
    div_stage_t          nxt;
    div_stage_t          held;

    assign dsh   = REM_BITS'(stg[k].den) << BIT;
    assign ge_re = stg[k].rem_re >= dsh;
    assign ge_im = stg[k].rem_im >= dsh;

    always_comb begin
      nxt = stg[k];
      if (ge_re) begin
        nxt.rem_re   = stg[k].rem_re - dsh;
        nxt.q_re[BIT] = 1'b1;
      end
      if (ge_im) begin
        nxt.rem_im   = stg[k].rem_im - dsh;
        nxt.q_im[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        held.vld <= 1'b0;
      end else if (en) begin
        held.vld <= nxt.vld;
      end
      if (en) begin
        held.is_div  <= nxt.is_div;
        held.dz      <= nxt.dz;
        held.neg_re  <= nxt.neg_re;
        held.neg_im  <= nxt.neg_im;
        held.big_re  <= nxt.big_re;
        held.big_im  <= nxt.big_im;
        held.rem_re  <= nxt.rem_re;
        held.rem_im  <= nxt.rem_im;
        held.den     <= nxt.den;
        held.q_re    <= nxt.q_re;
        held.q_im    <= nxt.q_im;
        held.pass_re <= nxt.pass_re;
        held.pass_im <= nxt.pass_im;
      end
    end

    assign stg[k+1] = held;
  end

endmodule

### hdl/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back: execution pipeline
// Products, sums, magnitudes, division and saturation into the output register.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_vld,
  input  item_t item,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t res_re,
  output word_t res_im,
  output logic  div_zero,
  output logic  overflowed
);

  logic en;

  // stage 1: products and short sums
  logic                        s1_vld;
  action_t                     s1_act;
  logic                        s1_dz;
  logic signed [PROD_BITS-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [WORD_BITS:0]   s1_re, s1_im;

  // stage 2: combined signed parts
  logic                        s2_vld;
  action_t                     s2_act;
  logic                        s2_dz;
  logic signed [SUM_BITS-1:0]  s2_re, s2_im;
  logic [MAG_BITS-1:0]         s2_den;

  // stage 3: sign and magnitude
  logic                        s3_vld;
  action_t                     s3_act;
  logic                        s3_dz;
  logic                        s3_neg_re, s3_neg_im;
  logic [MAG_BITS-1:0]         s3_mag_re, s3_mag_im;
  logic [MAG_BITS-1:0]         s3_den;
  logic [SUM_BITS-1:0]         ab_re, ab_im;

  div_stage_t                  d_in;
  div_stage_t                  d_out;
  logic [REM_BITS-1:0]         den_top;
  sat_t                        f_re, f_im;
  logic                        f_dz;

  assign en  = !out_valid || !out_stall;
  assign pop = en && item_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= item_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_act <= item.action;
      s1_dz  <= item.dz;
      p_rr   <= item.a_re * item.b_re;
      p_ii   <= item.a_im * item.b_im;
      p_ri   <= item.a_re * item.b_im;
      p_ir   <= item.a_im * item.b_re;
      p_bb   <= item.b_re * item.b_re;
      p_cc   <= item.b_im * item.b_im;
      if (item.action == ACT_SUB) begin
        s1_re <= item.a_re - item.b_re;
        s1_im <= item.a_im - item.b_im;
      end else begin
        s1_re <= item.a_re + item.b_re;
        s1_im <= item.a_im + item.b_im;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_act <= s1_act;
      s2_dz  <= s1_dz;
      s2_den <= MAG_BITS'($unsigned(p_bb)) + MAG_BITS'($unsigned(p_cc));
      unique case (s1_act)
        ACT_ADD, ACT_SUB: begin
          s2_re <= SUM_BITS'(s1_re);
          s2_im <= SUM_BITS'(s1_im);
        end
        ACT_MUL: begin
          s2_re <= SUM_BITS'(p_rr) - SUM_BITS'(p_ii);
          s2_im <= SUM_BITS'(p_ri) + SUM_BITS'(p_ir);
        end
        ACT_DIV: begin
          s2_re <= SUM_BITS'(p_rr) + SUM_BITS'(p_ii);
          s2_im <= SUM_BITS'(p_ir) - SUM_BITS'(p_ri);
        end
        default: begin
          s2_re <= '0;
          s2_im <= '0;
        end
      endcase
    end
  end

  assign ab_re = s2_re[SUM_BITS-1] ? SUM_BITS'(-s2_re) : SUM_BITS'(s2_re);
  assign ab_im = s2_im[SUM_BITS-1] ? SUM_BITS'(-s2_im) : SUM_BITS'(s2_im);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_act    <= s2_act;
      s3_dz     <= s2_dz;
      s3_den    <= s2_den;
      s3_neg_re <= s2_re[SUM_BITS-1];
      s3_neg_im <= s2_im[SUM_BITS-1];
      if (s2_act == ACT_MUL) begin
        s3_mag_re <= MAG_BITS'(ab_re >> FRAC_BITS);
        s3_mag_im <= MAG_BITS'(ab_im >> FRAC_BITS);
      end else begin
        s3_mag_re <= MAG_BITS'(ab_re);
        s3_mag_im <= MAG_BITS'(ab_im);
      end
    end
  end

  // divider entry: scaled numerators and quotient range check
  assign den_top = REM_BITS'(s3_den) << WORD_BITS;

  always_comb begin
    d_in         = '0;
    d_in.vld     = s3_vld;
    d_in.is_div  = (s3_act == ACT_DIV);
    d_in.dz      = s3_dz;
    d_in.neg_re  = s3_neg_re;
    d_in.neg_im  = s3_neg_im;
    d_in.den     = s3_den;
    d_in.rem_re  = REM_BITS'(s3_mag_re) << FRAC_BITS;
    d_in.rem_im  = REM_BITS'(s3_mag_im) << FRAC_BITS;
    d_in.big_re  = d_in.rem_re >= den_top;
    d_in.big_im  = d_in.rem_im >= den_top;
    d_in.pass_re = sat_mag(s3_neg_re, s3_mag_re);
    d_in.pass_im = sat_mag(s3_neg_im, s3_mag_im);
  end

  cau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .d_in  (d_in),
    .d_out (d_out)
  );

  always_comb begin
    f_dz = 1'b0;
    if (!d_out.is_div) begin
      f_re = d_out.pass_re;
      f_im = d_out.pass_im;
    end else if (d_out.dz) begin
      f_re = '0;
      f_im = '0;
      f_dz = 1'b1;
    end else begin
      f_re = d_out.big_re ? sat_mag(d_out.neg_re, MAG_BITS'(1) << (MAG_BITS - 1))
                          : sat_mag(d_out.neg_re, MAG_BITS'(d_out.q_re));
      f_im = d_out.big_im ? sat_mag(d_out.neg_im, MAG_BITS'(1) << (MAG_BITS - 1))
                          : sat_mag(d_out.neg_im, MAG_BITS'(d_out.q_im));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re     <= f_re.val;
      res_im     <= f_im.val;
      div_zero   <= f_dz;
      overflowed <= f_re.ovf || f_im.ovf;
    end
  end

endmodule

### dv/complex_arith_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_core_tb: self-checking testbench for the complex ALU
// Directed corner requests then random traffic with random idle on both
// sides. Each accepted request is predicted with wide exact arithmetic and
// compared field by field with the results in order.
// ----------------------------------------------------------------------------
module complex_arith_unit_core_tb;
  import cau_pkg::*;

  typedef struct {
    action_t act;
    word_t   a_re;
    word_t   a_im;
    word_t   b_re;
    word_t   b_im;
  } req_t;

  typedef struct {
    word_t re;
    word_t im;
    logic  dz;
    logic  ovf;
  } cplx_res_t;

  localparam int  PERIOD      = 8;
  localparam int  N_RANDOM    = 1200;
  localparam int  CYCLE_LIMIT = 400000;
  localparam word_t ONE       = word_t'(1 << FRAC_BITS);

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic [1:0] action = ACT_ADD;
  word_t a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t res_re, res_im;
  logic  div_zero, overflowed;

  req_t      pending_reqs[$];
  cplx_res_t expected_res[$];
  int        errors = 0;
  int        cycles = 0;
  int        n_accepted = 0;
  int        n_results = 0;
  int        n_ovf = 0;
  int        n_dz = 0;
  int        op_count[4] = '{0, 0, 0, 0};
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  complex_arith_unit_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_re(res_re), .res_im(res_im), .div_zero(div_zero), .overflowed(overflowed)
  );

  always #(PERIOD / 2) clk = ~clk;

  // signed magnitude to saturated word
  function automatic word_t saturate_mag(input logic neg, input logic [127:0] mag,
                                         inout logic ovf);
    logic [127:0] lim_pos;
    lim_pos = 128'(WORD_MAX);
    if (neg) begin
      if (mag > lim_pos + 1) begin
        ovf = 1'b1;
        return WORD_MIN;
      end
      return word_t'(-mag[WORD_BITS-1:0]);
    end
    if (mag > lim_pos) begin
      ovf = 1'b1;
      return WORD_MAX;
    end
    return word_t'(mag[WORD_BITS-1:0]);
  endfunction

  function automatic cplx_res_t complex_alu(input req_t r);
    cplx_res_t             o;
    logic signed [127:0]   ar, ai, br, bi, vre, vim;
    logic [127:0]          den, mre, mim;
    ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
    o.dz  = 1'b0;
    o.ovf = 1'b0;
    o.re  = '0;
    o.im  = '0;
    case (r.act)
      ACT_ADD: begin
        vre = ar + br;
        vim = ai + bi;
      end
      ACT_SUB: begin
        vre = ar - br;
        vim = ai - bi;
      end
      ACT_MUL: begin
        vre = ar * br - ai * bi;
        vim = ar * bi + ai * br;
      end
      default: begin
        vre = ar * br + ai * bi;
        vim = ai * br - ar * bi;
      end
    endcase
    mre = (vre < 0) ? 128'(-vre) : 128'(vre);
    mim = (vim < 0) ? 128'(-vim) : 128'(vim);
    if (r.act == ACT_MUL) begin
      mre = mre >> FRAC_BITS;
      mim = mim >> FRAC_BITS;
    end else if (r.act == ACT_DIV) begin
      if (br == 0 && bi == 0) begin
        o.dz = 1'b1;
        return o;
      end
      den = 128'(br * br + bi * bi);
      mre = (mre << FRAC_BITS) / den;
      mim = (mim << FRAC_BITS) / den;
    end
    o.re = saturate_mag(vre < 0 && mre != 0, mre, o.ovf);
    o.im = saturate_mag(vim < 0 && mim != 0, mim, o.ovf);
    return o;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return word_t'($urandom);
      4, 5, 6:    return word_t'($urandom_range(0, 32'h000C_0000)) - word_t'(32'h0006_0000);
      7:          return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      8:          return '0;
      default:    return word_t'($urandom) >>> $urandom_range(1, 24);
    endcase
  endfunction

  task automatic add_req(input action_t act, input word_t ar, input word_t ai,
                         input word_t br, input word_t bi);
    req_t r;
    r.act = act; r.a_re = ar; r.a_im = ai; r.b_re = br; r.b_im = bi;
    pending_reqs.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    logic drive;
    req_t r;
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        r = pending_reqs.pop_front();
        expected_res.push_back(complex_alu(r));
        op_count[r.act]++;
        n_accepted++;
        if (n_accepted % 400 < 100) send_gap = 0;
        else if ($urandom_range(0, 99) < 75) send_gap = 0;
        else if ($urandom_range(0, 99) < 85) send_gap = $urandom_range(1, 3);
        else send_gap = $urandom_range(8, 40);
      end
      drive = 1'b0;
      if (in_valid && in_stall) drive = 1'b1;
      else if (send_gap > 0) send_gap--;
      else if (pending_reqs.size() > 0) drive = 1'b1;
      if (drive) begin
        r = pending_reqs[0];
        action <= r.act;
        a_re <= r.a_re; a_im <= r.a_im; b_re <= r.b_re; b_im <= r.b_im;
      end
      in_valid <= drive;
    end
  end

  // monitor
  always @(posedge clk) begin
    cplx_res_t e;
    logic stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_res.size() == 0) begin
          errors++;
          $display("%0t: unexpected result re=%h im=%h", $time, res_re, res_im);
        end else begin
          e = expected_res.pop_front();
          if (e.dz) n_dz++;
          if (e.ovf) n_ovf++;
          if (res_re !== e.re) begin
            errors++;
            $display("%0t: res_re expected %h actual %h", $time, e.re, res_re);
          end
          if (res_im !== e.im) begin
            errors++;
            $display("%0t: res_im expected %h actual %h", $time, e.im, res_im);
          end
          if (div_zero !== e.dz) begin
            errors++;
            $display("%0t: div_zero expected %b actual %b", $time, e.dz, div_zero);
          end
          if (overflowed !== e.ovf) begin
            errors++;
            $display("%0t: overflowed expected %b actual %b", $time, e.ovf, overflowed);
          end
        end
      end
      // long hold so the block backs up into its input
      if (!hold_done && n_accepted >= 300) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        stall = 1'b1;
      end else begin
        stall = 1'b0;
        if (n_results % 400 >= 100 && $urandom_range(0, 99) < 20)
          recv_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(1, 3);
      end
      out_stall <= stall;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    action_t act;
    word_t   br, bi;
    // directed corners
    add_req(ACT_ADD, ONE, -ONE, ONE, ONE);
    add_req(ACT_ADD, WORD_MAX, WORD_MIN, ONE, -ONE);
    add_req(ACT_ADD, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
    add_req(ACT_SUB, ONE * 3, ONE, ONE, ONE * 2);
    add_req(ACT_SUB, WORD_MIN, WORD_MAX, ONE, -ONE);
    add_req(ACT_SUB, '0, '0, WORD_MIN, WORD_MAX);
    add_req(ACT_MUL, ONE * 2, ONE * 3, ONE * 4, -ONE * 5);
    add_req(ACT_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    add_req(ACT_MUL, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX);
    add_req(ACT_MUL, word_t'(1), word_t'(-1), word_t'(1), word_t'(1));
    add_req(ACT_MUL, -ONE, '0, word_t'(3), word_t'(-7));
    add_req(ACT_DIV, ONE * 5, ONE, ONE * 2, -ONE);
    add_req(ACT_DIV, ONE, ONE, '0, '0);
    add_req(ACT_DIV, '0, '0, '0, '0);
    add_req(ACT_DIV, WORD_MAX, WORD_MIN, word_t'(1), '0);
    add_req(ACT_DIV, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    add_req(ACT_DIV, ONE, '0, WORD_MAX, WORD_MAX);
    add_req(ACT_DIV, word_t'(-1), word_t'(1), ONE * 3, '0);
    add_req(ACT_DIV, WORD_MIN, '0, word_t'(-1), '0);
    add_req(ACT_DIV, '0, ONE, '0, WORD_MIN);
    for (int i = 0; i < N_RANDOM; i++) begin
      act = action_t'($urandom_range(0, 3));
      br = rand_word();
      bi = rand_word();
      if (act == ACT_DIV && $urandom_range(0, 19) == 0) begin
        br = '0;
        bi = '0;
      end
      add_req(act, rand_word(), rand_word(), br, bi);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() > 0 || expected_res.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("ran %0d requests: add %0d sub %0d mul %0d div %0d", n_accepted,
             op_count[ACT_ADD], op_count[ACT_SUB], op_count[ACT_MUL], op_count[ACT_DIV]);
    $display("results %0d, saturated %0d, divide by zero %0d", n_results, n_ovf, n_dz);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
